// ----- hw/rtl/wpf_pkg.sv -----
// wpf_pkg: types, codes and constants shared by the waypoint path follower
// no dependencies; imported by every module of the block
package wpf_pkg;

    // input kind codes
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // life state codes
    localparam logic [1:0] LIFE_ALIVE = 2'd0;
    localparam logic [1:0] LIFE_OUT   = 2'd1;
    localparam logic [1:0] LIFE_DEAD  = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATH_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y    = 3'd4;

    // reset value of speed, 1.0 in q8.8
    localparam logic [15:0] SPEED_ONE = 16'd256;

    // angles in 1/64 degree
    localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd5760;

    // rounding bias for the blend, half of one q16 step
    localparam logic signed [34:0] ROUND_HALF = 35'sd32768;

    // saturation limits of a 16 bit signed result
    localparam logic signed [17:0] SAT_MAX = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN = -18'sd32768;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         point_index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_heading;
        logic [15:0]        dt;
        logic               paused;
        logic [1:0]         life_state;
    } wpf_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
        logic               at_end;
    } wpf_result_t;

    // one waypoint table entry
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] h;
    } wpf_point_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_DELAY,
        S_SEGMENT,
        S_READ,
        S_MUL,
        S_FINISH
    } wpf_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic accum;
        logic delay_step;
        logic seg_step;
        logic read_step;
        logic mul_step;
        logic out_load;
    } wpf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_go;
        logic delay_hold;
        logic path_empty;
        logic out_free;
    } wpf_status_t;

endpackage

// ----- hw/rtl/wpf_ctrl.sv -----
// wpf_ctrl: sequencing state machine for one tick transaction
// depends on wpf_pkg (state, command and status types)
module wpf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  wpf_pkg::wpf_status_t status,
    output wpf_pkg::wpf_cmd_t    cmd
);
    import wpf_pkg::*;

    wpf_state_t state_reg;
    wpf_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && status.tick_go)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:   state_next = S_DELAY;
            S_DELAY:
            begin
                if (status.delay_hold || status.path_empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SEGMENT;
                end
            end
            S_SEGMENT: state_next = S_READ;
            S_READ:    state_next = S_MUL;
            S_MUL:     state_next = S_FINISH;
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            S_ACCUM:   cmd.accum      = 1'b1;
            S_DELAY:   cmd.delay_step = 1'b1;
            S_SEGMENT: cmd.seg_step   = 1'b1;
            S_READ:    cmd.read_step  = 1'b1;
            S_MUL:     cmd.mul_step   = 1'b1;
            S_FINISH:  cmd.out_load   = status.out_free;
            default:   cmd            = '0;
        endcase
    end

endmodule

// ----- hw/rtl/wpf_datapath.sv -----
// wpf_datapath: configuration registers, waypoint memory, time and blend arithmetic
// depends on wpf_pkg; sequenced by wpf_ctrl through wpf_cmd_t
module wpf_datapath #(
    parameter int PATH_DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [wpf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wpf_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wpf_pkg::wpf_item_t                   item_data,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output wpf_pkg::wpf_result_t                 result_data,
    input  wpf_pkg::wpf_cmd_t                    cmd,
    output wpf_pkg::wpf_status_t                 status
);
    import wpf_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int NW = $clog2(PATH_DEPTH + 1);

    // configuration registers
    logic [8:0]         path_length_reg;
    logic [15:0]        speed_reg;
    logic [31:0]        start_delay_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;

    // tick state
    logic [31:0] elapsed_reg, elapsed_next;
    logic        delay_armed_reg, delay_armed_next;
    logic        end_reached_reg, end_reached_next;

    // work registers
    logic [31:0]        dt_prod_reg;
    logic [AW-1:0]      seg_reg;
    logic [15:0]        frac_reg;
    logic               last_reg;
    wpf_point_t         pa_reg, pb_reg;
    logic signed [33:0] prod_x_reg, prod_y_reg, prod_h_reg;

    // output register
    logic        result_valid_reg;
    wpf_result_t result_reg;

    // waypoint memory
    wpf_point_t mem [PATH_DEPTH];

    // combinational signals
    logic               is_tick, is_write, is_restart, suppress;
    logic               slot_ok;
    logic [AW-1:0]      wr_addr, addr_a, addr_b;
    logic [32:0]        elapsed_sum;
    logic               delay_active, delay_hold;
    logic               path_over;
    logic [NW-1:0]      n_cur, n_last;
    logic [35:0]        pos;
    logic [19:0]        pos_int;
    logic               last_now;
    logic signed [16:0] dx, dy, dh, dh_eff, frac_s;
    logic               wrap;
    logic signed [15:0] bx, by, bh;

    // blend: a plus rounded-down (delta * frac + half) / 65536
    function automatic logic signed [15:0] round_blend(
        input logic signed [15:0] a,
        input logic signed [33:0] p
    );
        logic signed [34:0] biased;
        logic signed [18:0] step;
        logic signed [18:0] sum;
        biased = 35'(p) + ROUND_HALF;
        step   = $signed(biased[34:16]);
        sum    = 19'(a) + step;
        return sum[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[15:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[15:0];
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_length_reg <= '0;
            speed_reg       <= SPEED_ONE;
            start_delay_reg <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
        end
        else if (cfg_write)
        begin
            priority case (cfg_index)
                CFG_PATH_LENGTH: path_length_reg <= cfg_data[8:0];
                CFG_SPEED:       speed_reg       <= cfg_data[15:0];
                CFG_START_DELAY: start_delay_reg <= cfg_data[31:0];
                CFG_OFFSET_X:    offset_x_reg    <= $signed(cfg_data[15:0]);
                CFG_OFFSET_Y:    offset_y_reg    <= $signed(cfg_data[15:0]);
                default:         ;
            endcase
        end
    end

    // decode of the incoming transaction
    assign is_tick    = (item_data.kind == KIND_TICK);
    assign is_write   = (item_data.kind == KIND_WRITE);
    assign is_restart = (item_data.kind == KIND_RESTART);
    assign suppress   = item_data.paused
                        || (item_data.life_state == LIFE_DEAD)
                        || ((item_data.life_state == LIFE_OUT) && end_reached_reg);
    assign slot_ok    = (32'(item_data.point_index) < 32'(PATH_DEPTH));
    assign wr_addr    = AW'(item_data.point_index);

    // waypoint write port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_write && slot_ok)
        begin
            mem[wr_addr] <= '{x: item_data.point_x, y: item_data.point_y,
                              h: item_data.point_heading};
        end
    end

    // two registered read ports: segment start and end
    assign addr_a = seg_reg;
    assign addr_b = last_reg ? seg_reg : seg_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.read_step)
        begin
            pa_reg <= mem[addr_a];
            pb_reg <= mem[addr_b];
        end
    end

    // elapsed time and start delay
    assign elapsed_sum  = {1'b0, elapsed_reg} + {9'b0, dt_prod_reg[31:8]};
    assign delay_active = delay_armed_reg && (start_delay_reg != '0);
    assign delay_hold   = delay_active && (elapsed_reg < start_delay_reg);

    // path length limited to the table
    assign path_over = (32'(path_length_reg) > 32'(PATH_DEPTH));
    assign n_cur     = path_over ? NW'(PATH_DEPTH) : NW'(path_length_reg);
    assign n_last    = n_cur - NW'(1);

    // path position: elapsed times ten steps per second
    assign pos      = 36'({elapsed_reg, 3'b000}) + 36'({elapsed_reg, 1'b0});
    assign pos_int  = pos[35:16];
    assign last_now = (pos_int >= 20'(n_last));

    always_comb
    begin
        elapsed_next     = elapsed_reg;
        delay_armed_next = delay_armed_reg;
        end_reached_next = end_reached_reg;
        if (cmd.accept && is_restart)
        begin
            elapsed_next     = '0;
            end_reached_next = 1'b0;
            delay_armed_next = 1'b1;
        end
        if (cmd.accum)
        begin
            elapsed_next = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
        end
        if (cmd.delay_step && delay_active && !delay_hold)
        begin
            elapsed_next     = '0;
            delay_armed_next = 1'b0;
        end
        if (cmd.seg_step && last_now)
        begin
            end_reached_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= '0;
            delay_armed_reg <= 1'b0;
            end_reached_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg     <= elapsed_next;
            delay_armed_reg <= delay_armed_next;
            end_reached_reg <= end_reached_next;
        end
    end

    // tick scale product
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_tick)
        begin
            dt_prod_reg <= item_data.dt * speed_reg;
        end
    end

    // segment pick; the last point is taken unblended
    always_ff @(posedge clk)
    begin
        if (cmd.seg_step)
        begin
            seg_reg  <= last_now ? AW'(n_last) : AW'(pos_int);
            frac_reg <= last_now ? 16'd0 : pos[15:0];
            last_reg <= last_now;
        end
    end

    // blend products, heading kept when the turn exceeds half a circle
    assign frac_s = $signed({1'b0, frac_reg});
    assign dx     = 17'(pb_reg.x) - 17'(pa_reg.x);
    assign dy     = 17'(pb_reg.y) - 17'(pa_reg.y);
    assign dh     = 17'(pb_reg.h) - 17'(pa_reg.h);
    assign wrap   = (dh > HALF_TURN) || (dh < -HALF_TURN);
    assign dh_eff = wrap ? 17'sd0 : dh;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            prod_x_reg <= dx * frac_s;
            prod_y_reg <= dy * frac_s;
            prod_h_reg <= dh_eff * frac_s;
        end
    end

    // rounding
    assign bx = round_blend(pa_reg.x, prod_x_reg);
    assign by = round_blend(pa_reg.y, prod_y_reg);
    assign bh = round_blend(pa_reg.h, prod_h_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.pos_x   <= sat16(18'(bx) + 18'(offset_x_reg));
            result_reg.pos_y   <= sat16(18'(by) + 18'(offset_y_reg));
            result_reg.heading <= sat16(18'(bh) - QUARTER_TURN);
            result_reg.at_end  <= end_reached_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // status to the controller
    assign status.tick_go    = is_tick && !suppress;
    assign status.delay_hold = delay_hold;
    assign status.path_empty = (n_cur == '0);
    assign status.out_free   = !result_valid_reg || !result_stall;

endmodule

// ----- hw/rtl/waypoint_path_follower.sv -----
// waypoint path follower: a moving tick steps through accumulate, delay, segment, read,
// multiply and finish (round, load output) before the next transaction is taken; a tick
// ending in the start delay or on an empty path returns to idle after delay; writes,
// restarts and suppressed ticks end on acceptance; a stalled result holds the input off
// asynchronous active-low reset clears control state and the configuration
// registers; the waypoint memory is not cleared and needs no clearing pass
module waypoint_path_follower #(
    parameter int PATH_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  wpf_pkg::wpf_item_t              item_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output wpf_pkg::wpf_result_t            result_data
);
    import wpf_pkg::*;

    wpf_cmd_t    cmd;
    wpf_status_t status;

    // sequencer
    wpf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic and storage
    wpf_datapath #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ----- hw/rtl/wpf_checker.sv -----
// wpf_checker: port-level checks of the waypoint path follower
// depends on wpf_pkg; bound to waypoint_path_follower at the end of this file
module wpf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input wpf_pkg::wpf_item_t   item_data,
    input logic                 result_valid,
    input logic                 result_stall,
    input wpf_pkg::wpf_result_t result_data
);
    import wpf_pkg::*;

    // a stalled result stays and holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result transaction changed");

    // a live unpaused tick starts a job that holds the input off
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item_data.kind == KIND_TICK)
        && !item_data.paused && (item_data.life_state == LIFE_ALIVE) |=> item_stall)
        else $error("moving tick did not occupy the block");

    // writes and restarts leave the input free in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall
        && ((item_data.kind == KIND_WRITE) || (item_data.kind == KIND_RESTART))
        |=> !item_stall)
        else $error("write or restart held the input");

    // a new result only comes out of a tick in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without a tick in progress");

endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
